@@ rtl/core/tirf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tirf_pkg
// Shared codes and types of the telnet refusing filter.
// ----------------------------------------------------------------------------
package tirf_pkg;

  localparam logic [7:0] TEL_SE   = 8'd240;
  localparam logic [7:0] TEL_SB   = 8'd250;
  localparam logic [7:0] TEL_WILL = 8'd251;
  localparam logic [7:0] TEL_WONT = 8'd252;
  localparam logic [7:0] TEL_DO   = 8'd253;
  localparam logic [7:0] TEL_DONT = 8'd254;
  localparam logic [7:0] TEL_IAC  = 8'd255;

  // job queue between parser and emitter
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    PH_PLAIN   = 3'd0,
    PH_IAC     = 3'd1,
    PH_OPT     = 3'd2,
    PH_SUB     = 3'd3,
    PH_SUB_IAC = 3'd4
  } parse_phase_e;

  // beats of a three-word refusal
  typedef enum logic [1:0] {
    BEAT_IAC  = 2'd0,
    BEAT_VERB = 2'd1,
    BEAT_OPT  = 2'd2
  } beat_e;

  typedef struct packed {
    logic       is_refusal;  // 1: IAC verb opt toward peer, 0: one plain word
    logic       is_wont;
    logic [7:0] data;        // plain byte or option byte
  } job_t;

endpackage
`default_nettype wire

@@ rtl/core/tirf_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tirf_front
// Telnet parser: tracks the command phase and posts one job per byte that
// yields output.
// ----------------------------------------------------------------------------
module tirf_front import tirf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       segment_end_i,
  input  wire logic       queue_full_i,
  output logic            push_o,
  output job_t            job_o
);

  parse_phase_e phase_q, phase_d;
  logic         wont_q, wont_d;
  logic         has_job;
  logic         accept;

  assign in_ready_o = ~queue_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign push_o     = accept & has_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      wont_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      wont_q  <= wont_d;
    end
  end

  always_comb begin
    phase_d           = phase_q;
    wont_d            = wont_q;
    has_job           = 1'b0;
    job_o.is_refusal  = 1'b0;
    job_o.is_wont     = wont_q;
    job_o.data        = data_byte_i;
    case (phase_q)
      PH_IAC: begin
        if (data_byte_i == TEL_IAC) begin
          has_job = 1'b1;
          phase_d = PH_PLAIN;
        end else if (data_byte_i == TEL_SB) begin
          phase_d = PH_SUB;
        end else if (data_byte_i == TEL_DO || data_byte_i == TEL_DONT) begin
          wont_d  = 1'b1;
          phase_d = PH_OPT;
        end else if (data_byte_i == TEL_WILL || data_byte_i == TEL_WONT) begin
          wont_d  = 1'b0;
          phase_d = PH_OPT;
        end else begin
          phase_d = PH_PLAIN;
        end
      end
      PH_OPT: begin
        has_job          = 1'b1;
        job_o.is_refusal = 1'b1;
        phase_d          = PH_PLAIN;
      end
      PH_SUB: begin
        if (data_byte_i == TEL_IAC) phase_d = PH_SUB_IAC;
      end
      PH_SUB_IAC: begin
        if (data_byte_i == TEL_SE) phase_d = PH_PLAIN;
        else if (data_byte_i != TEL_IAC) phase_d = PH_SUB;
      end
      default: begin
        // plain, and unused codes behave as plain
        if (data_byte_i == TEL_IAC) phase_d = PH_IAC;
        else has_job = 1'b1;
      end
    endcase
    if (segment_end_i) phase_d = PH_PLAIN;
  end

endmodule
`default_nettype wire

@@ rtl/core/tirf_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tirf_queue
// Short job FIFO between parser and emitter.
// ----------------------------------------------------------------------------
module tirf_queue import tirf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      push_job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output job_t      head_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/tirf_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tirf_back
// Emitter: turns the job at the queue head into one or three output words.
// ----------------------------------------------------------------------------
module tirf_back import tirf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       empty_i,
  input  job_t            head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            destination_o,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o
);

  beat_e beat_q, beat_d;
  logic  take;

  assign out_valid_o   = ~empty_i;
  assign take          = out_valid_o & out_ready_i;
  assign destination_o = head_i.is_refusal;
  assign pop_o         = take & last_of_run_o;

  always_comb begin
    out_byte_o    = head_i.data;
    last_of_run_o = 1'b1;
    if (head_i.is_refusal) begin
      case (beat_q)
        BEAT_IAC: begin
          out_byte_o    = TEL_IAC;
          last_of_run_o = 1'b0;
        end
        BEAT_VERB: begin
          out_byte_o    = head_i.is_wont ? TEL_WONT : TEL_DONT;
          last_of_run_o = 1'b0;
        end
        default: begin
          out_byte_o    = head_i.data;
          last_of_run_o = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    beat_d = beat_q;
    if (take) begin
      if (last_of_run_o) beat_d = BEAT_IAC;
      else beat_d = (beat_q == BEAT_IAC) ? BEAT_VERB : BEAT_OPT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) beat_q <= BEAT_IAC;
    else beat_q <= beat_d;
  end

endmodule
`default_nettype wire

@@ rtl/core/telnet_iac_refusing_filter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// telnet_iac_refusing_filter
// Telnet receive filter: passes data, unescapes IAC IAC, drops commands and
// subnegotiation, and answers every WILL, WONT, DO and DONT with a refusal.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  in      | in_valid_i/in_ready_o  | data_byte_i, segment_end_i
//  out     | out_valid_o/out_ready_i| destination_o, out_byte_o, last_of_run_o
//
// One input byte per cycle; a byte that yields output is registered as a job
// in the queue and leaves from its head. A refusal is sent as three output
// words, stepped by the emitter's beat counter; the two-entry job queue
// absorbs the difference. Input stalls only while the queue is full. Reset
// puts the parser in the plain phase and empties the queue.
// ----------------------------------------------------------------------------
module telnet_iac_refusing_filter import tirf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       segment_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            destination_o,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o
);

  job_t push_job, head_job;
  logic push, pop, full, empty;

  tirf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .segment_end_i(segment_end_i),
    .queue_full_i (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  tirf_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .head_o    (head_job)
  );

  tirf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .destination_o(destination_o),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule
`default_nettype wire
